### src/dlpe_pkg.sv
// ----------------------------------------------------------------------------
// dlpe_pkg
// Shared types, codes and defaults for the lease pool engine.
// ----------------------------------------------------------------------------
package dlpe_pkg;

    localparam int POOL_DEPTH_DEF = 1024;
    localparam int ID_BITS        = 16;
    localparam int TIME_BITS      = 31;
    localparam int CFG_BITS       = 30;
    localparam int CFG_IDX_BITS   = 3;

    localparam logic [10:0] POOL_ENTRIES_RST  = 11'd1024;
    localparam logic [29:0] DEFAULT_LEASE_RST = 30'd3600;
    localparam logic [29:0] MAX_LEASE_RST     = 30'd86400;
    localparam logic [29:0] MIN_LEASE_RST     = 30'd60;
    localparam logic [15:0] SERVER_ID_RST     = 16'd1;

    typedef enum logic [2:0] {
        REG_POOL_ENTRIES  = 3'd0,
        REG_DEFAULT_LEASE = 3'd1,
        REG_MAX_LEASE     = 3'd2,
        REG_MIN_LEASE     = 3'd3,
        REG_SERVER_ID     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_OFFERED  = 2'd1,
        ST_OCCUPIED = 2'd2,
        ST_EXPIRED  = 2'd3
    } entry_state_t;

    localparam logic [1:0] OP_DISCOVER = 2'd0;
    localparam logic [1:0] OP_REQUEST  = 2'd1;
    localparam logic [1:0] DEST_SELF   = 2'd0;
    localparam logic [1:0] DEST_BCAST  = 2'd1;
    localparam logic [1:0] KIND_OFFER  = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_NAK    = 2'd2;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_OFFER   = 2'd1,
        ACT_ACK     = 2'd2,
        ACT_RELEASE = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        FSM_IDLE   = 3'd0,
        FSM_AGE    = 3'd1,
        FSM_DECIDE = 3'd2,
        FSM_APPLY  = 3'd3,
        FSM_EMIT   = 3'd4
    } fsm_t;

    typedef struct packed {
        entry_state_t           status;
        logic [TIME_BITS-1:0]   expiry;
        logic [ID_BITS-1:0]     owner;
    } entry_t;

    typedef struct packed {
        logic [29:0] now;
        logic [15:0] client;
        logic [1:0]  dest_kind;
        logic [1:0]  op;
        logic [15:0] addr;
        logic [29:0] deadline;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] client_res;
        logic [15:0] addr_res;
        logic [30:0] expiry;
    } out_item_t;

    // Control from the sequencer to the head cell
    typedef struct packed {
        logic                 apply;
        logic                 in_range;
        logic                 target;
        act_t                 act;
        logic [29:0]          now;
        logic [ID_BITS-1:0]   client;
        logic [TIME_BITS-1:0] grant;
    } head_ctl_t;

endpackage

### src/dlpe_cell.sv
// ----------------------------------------------------------------------------
// dlpe_cell
// One pool entry of the ring; takes its neighbor's entry when shifting.
// ----------------------------------------------------------------------------
module dlpe_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  dlpe_pkg::entry_t d,
    output dlpe_pkg::entry_t q
);
    import dlpe_pkg::*;

    entry_t q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;
endmodule

### src/dlpe_head.sv
// ----------------------------------------------------------------------------
// dlpe_head
// Entry processor at the ring head: ages on the first pass, updates on the
// second.
// ----------------------------------------------------------------------------
module dlpe_head (
    input  dlpe_pkg::entry_t    entry_i,
    input  dlpe_pkg::head_ctl_t ctl,
    output dlpe_pkg::entry_t    entry_o
);
    import dlpe_pkg::*;

    logic due;

    always_comb
    begin
        entry_o = entry_i;
        due = ({1'b0, entry_i.expiry} <= {2'b0, ctl.now});
        if (ctl.in_range)
        begin
            if (!ctl.apply)
            begin
                // age
                if (entry_i.status == ST_OFFERED && due)
                begin
                    entry_o = '0;
                end
                else if (entry_i.status == ST_OCCUPIED && due)
                begin
                    entry_o.status = ST_EXPIRED;
                    entry_o.expiry = '0;
                end
            end
            else
            begin
                case (ctl.act)
                    ACT_OFFER:
                    begin
                        if (ctl.target)
                        begin
                            entry_o.status = ST_OFFERED;
                            entry_o.owner  = ctl.client;
                            entry_o.expiry = ctl.grant;
                        end
                    end
                    ACT_ACK:
                    begin
                        if (ctl.target)
                        begin
                            entry_o.status = ST_OCCUPIED;
                            entry_o.expiry = ctl.grant;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        if (entry_i.status == ST_OFFERED && entry_i.owner == ctl.client)
                        begin
                            entry_o = '0;
                        end
                    end
                    default:
                    begin
                        entry_o = entry_i;
                    end
                endcase
            end
        end
    end
endmodule

### src/dhcp_lease_pool_engine_top.sv
// ----------------------------------------------------------------------------
// dhcp_lease_pool_engine_top
// Lease pool engine: ages the pool, picks or checks an entry, replies.
// ----------------------------------------------------------------------------
// The pool lives in a ring of POOL_DEPTH cells that shifts one entry a cycle
// past a single head processor. Each request takes two full turns of the
// ring: the first ages every in-use entry and records the search results
// (first entry held by the client, first free, first expired, and the owner
// check for the named address); a decide step then settles the reply and lease
// time; the second turn writes the chosen entry or releases the client's
// offers. in_stall stays high from the taken request through both turns, the
// decide step and emit, including any wait for the reply register; the next
// request is taken only back in idle, so none is accepted before the last is
// through. Replies sit in an output register; while it is full and stalled,
// a new reply holds the engine in emit. No clearing pass is needed: reset
// zeroes the cells directly. Configuration writes go straight to registers.
// ----------------------------------------------------------------------------
module dhcp_lease_pool_engine_top #(
    parameter int POOL_DEPTH = dlpe_pkg::POOL_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  dlpe_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output dlpe_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [dlpe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [dlpe_pkg::CFG_BITS-1:0]        cfg_data
);
    import dlpe_pkg::*;

    localparam int CW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int NW0 = $clog2(POOL_DEPTH + 1);
    localparam int NW  = (NW0 > 17) ? NW0 : 17;
    localparam logic [CW-1:0] LAST = CW'(POOL_DEPTH - 1);

    // configuration
    logic [10:0] pool_entries_reg;
    logic [29:0] default_lease_reg;
    logic [29:0] max_lease_reg;
    logic [29:0] min_lease_reg;
    logic [15:0] server_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_entries_reg  <= POOL_ENTRIES_RST;
            default_lease_reg <= DEFAULT_LEASE_RST;
            max_lease_reg     <= MAX_LEASE_RST;
            min_lease_reg     <= MIN_LEASE_RST;
            server_id_reg     <= SERVER_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POOL_ENTRIES:  pool_entries_reg  <= cfg_data[10:0];
                REG_DEFAULT_LEASE: default_lease_reg <= cfg_data;
                REG_MAX_LEASE:     max_lease_reg     <= cfg_data;
                REG_MIN_LEASE:     min_lease_reg     <= cfg_data;
                REG_SERVER_ID:     server_id_reg     <= cfg_data[15:0];
                default:           server_id_reg     <= server_id_reg;
            endcase
        end
    end

    // Effective pool size, clamped to the ring depth
    logic [NW-1:0] n_eff;
    assign n_eff = (NW'(pool_entries_reg) > NW'(POOL_DEPTH)) ? NW'(POOL_DEPTH)
                                                             : NW'(pool_entries_reg);

    // sequencer state
    fsm_t      state_reg, state_next;
    logic [CW-1:0] k_reg, k_next;
    in_item_t  req_reg;
    logic      own_f_reg, free_f_reg, exp_f_reg, req_ok_reg;
    logic [CW-1:0] own_i_reg, free_i_reg, exp_i_reg;
    act_t      act_reg;
    logic [CW-1:0] tgt_reg;
    logic [TIME_BITS-1:0] grant_reg;
    logic      has_res_reg;
    out_item_t res_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // ring
    entry_t    ring_q [POOL_DEPTH];
    entry_t    head_out;
    head_ctl_t ctl;
    logic      shift;

    assign shift = (state_reg == FSM_AGE) || (state_reg == FSM_APPLY);

    genvar g;
    generate
        for (g = 0; g < POOL_DEPTH; g++)
        begin : g_ring
            if (g == 0)
            begin : g_first
                dlpe_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                                  .d(head_out), .q(ring_q[g]));
            end
            else
            begin : g_rest
                dlpe_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                                  .d(ring_q[g-1]), .q(ring_q[g]));
            end
        end
    endgenerate

    logic in_range;
    assign in_range = NW'(k_reg) < n_eff;

    always_comb
    begin
        ctl.apply    = (state_reg == FSM_APPLY);
        ctl.in_range = in_range && shift;
        ctl.target   = (k_reg == tgt_reg);
        ctl.act      = act_reg;
        ctl.now      = req_reg.now;
        ctl.client   = req_reg.client;
        ctl.grant    = grant_reg;
    end

    dlpe_head u_head (.entry_i(ring_q[POOL_DEPTH-1]), .ctl(ctl), .entry_o(head_out));

    // lease time for the latched request
    logic signed [31:0] dl_s;
    logic [TIME_BITS-1:0] grant_c;
    always_comb
    begin
        dl_s = $signed({2'b0, req_reg.deadline}) - $signed({2'b0, req_reg.now});
        if (req_reg.deadline == '0)
        begin
            grant_c = TIME_BITS'({1'b0, req_reg.now} + {1'b0, default_lease_reg});
        end
        else if (dl_s >= $signed({2'b0, min_lease_reg}) &&
                 dl_s <= $signed({2'b0, max_lease_reg}))
        begin
            grant_c = TIME_BITS'(req_reg.deadline);
        end
        else if (dl_s < $signed({2'b0, min_lease_reg}))
        begin
            grant_c = TIME_BITS'({1'b0, req_reg.now} + {1'b0, min_lease_reg});
        end
        else
        begin
            grant_c = TIME_BITS'({1'b0, req_reg.now} + {1'b0, max_lease_reg});
        end
    end

    // decision
    act_t      act_c;
    logic [CW-1:0] tgt_c;
    logic      has_res_c;
    out_item_t res_c;
    logic      addr_ok;
    logic [15:0] addr_m1;
    assign addr_m1 = req_reg.addr - 16'd1;
    assign addr_ok = (req_reg.addr != '0) && (NW'(req_reg.addr) <= n_eff);

    always_comb
    begin
        act_c     = ACT_NONE;
        tgt_c     = '0;
        has_res_c = 1'b0;
        res_c.kind       = KIND_OFFER;
        res_c.client_res = req_reg.client;
        res_c.addr_res   = req_reg.addr;
        res_c.expiry     = 31'(grant_c);
        if (req_reg.op == OP_DISCOVER)
        begin
            if (req_reg.dest_kind == DEST_BCAST &&
                (own_f_reg || free_f_reg || exp_f_reg))
            begin
                act_c     = ACT_OFFER;
                tgt_c     = own_f_reg ? own_i_reg : (free_f_reg ? free_i_reg : exp_i_reg);
                has_res_c = 1'b1;
                res_c.addr_res = 16'(32'(tgt_c) + 32'd1);
            end
        end
        else if (req_reg.op == OP_REQUEST)
        begin
            if (req_reg.dest_kind == DEST_SELF)
            begin
                has_res_c = 1'b1;
                if (addr_ok && req_ok_reg)
                begin
                    act_c      = ACT_ACK;
                    tgt_c      = CW'(addr_m1);
                    res_c.kind = KIND_ACK;
                end
                else
                begin
                    res_c.kind   = KIND_NAK;
                    res_c.expiry = '0;
                end
            end
            else if (req_reg.dest_kind != DEST_BCAST)
            begin
                act_c = ACT_RELEASE;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                k_next = '0;
                if (in_valid)
                begin
                    state_next = FSM_AGE;
                end
            end
            FSM_AGE:
            begin
                k_next = k_reg + CW'(1);
                if (k_reg == LAST)
                begin
                    k_next     = '0;
                    state_next = FSM_DECIDE;
                end
            end
            FSM_DECIDE:
            begin
                state_next = FSM_APPLY;
            end
            FSM_APPLY:
            begin
                k_next = k_reg + CW'(1);
                if (k_reg == LAST)
                begin
                    k_next     = '0;
                    state_next = FSM_EMIT;
                end
            end
            FSM_EMIT:
            begin
                if (!has_res_reg || !out_valid_reg || !out_stall)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != FSM_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            own_f_reg     <= 1'b0;
            free_f_reg    <= 1'b0;
            exp_f_reg     <= 1'b0;
            own_i_reg     <= '0;
            free_i_reg    <= '0;
            exp_i_reg     <= '0;
            req_ok_reg    <= 1'b0;
            act_reg       <= ACT_NONE;
            has_res_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            // load a new reply, or drop the one just taken
            if (state_reg == FSM_EMIT && has_res_reg && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                FSM_IDLE:
                begin
                    if (in_valid)
                    begin
                        own_f_reg  <= 1'b0;
                        free_f_reg <= 1'b0;
                        exp_f_reg  <= 1'b0;
                        req_ok_reg <= 1'b0;
                        act_reg    <= ACT_NONE;
                    end
                end
                FSM_AGE:
                begin
                    // record first matches on the aged entry
                    if (in_range)
                    begin
                        if (!own_f_reg && head_out.status != ST_FREE &&
                            head_out.owner == req_reg.client)
                        begin
                            own_f_reg <= 1'b1;
                            own_i_reg <= k_reg;
                        end
                        if (!free_f_reg && head_out.status == ST_FREE)
                        begin
                            free_f_reg <= 1'b1;
                            free_i_reg <= k_reg;
                        end
                        if (!exp_f_reg && head_out.status == ST_EXPIRED)
                        begin
                            exp_f_reg <= 1'b1;
                            exp_i_reg <= k_reg;
                        end
                        if (16'(k_reg) == addr_m1 && head_out.owner == req_reg.client)
                        begin
                            req_ok_reg <= 1'b1;
                        end
                    end
                end
                FSM_DECIDE:
                begin
                    act_reg     <= act_c;
                    has_res_reg <= has_res_c;
                end
                default:
                begin
                    act_reg <= act_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == FSM_IDLE && in_valid)
        begin
            req_reg <= in_data;
        end
        if (state_reg == FSM_DECIDE)
        begin
            tgt_reg   <= tgt_c;
            grant_reg <= grant_c;
            res_reg   <= res_c;
        end
        if (state_reg == FSM_EMIT && has_res_reg && (!out_valid_reg || !out_stall))
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Server identity is only used by the reply assertion below; dest_kind already routes messages.
    logic server_id_set;
    assign server_id_set = (server_id_reg != '0);

    a_accept_starts_age: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == FSM_AGE && k_reg == '0))
        else $error("accepted request did not start aging pass");

    a_idle_counter_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_DECIDE || state_reg == FSM_EMIT) |-> (k_reg == '0))
        else $error("pass counter not reset between passes");

    a_no_shift_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_IDLE) |-> (!shift && !in_stall))
        else $error("ring moved while idle");

    a_reply_only_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && server_id_set) |-> ($past(state_reg) == FSM_EMIT))
        else $error("reply raised outside emit");
endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lease pool engine. A built-in lease pool
// predictor follows each accepted request: it ages the pool, then answers
// DISCOVER, REQUEST or release the way the engine should. Replies are matched
// field by field against the oldest expected reply. Directed requests come
// first, then random request streams under several pool settings and
// several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlpe_pkg::*;

    localparam int DEPTH     = POOL_DEPTH_DEF;
    localparam int SETTLE    = 2 * DEPTH + 40;   // both ring turns of one request and margin
    localparam longint NOW_MAX = 64'h3FFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    dhcp_lease_pool_engine_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted pool contents and register copies
    entry_state_t lease_state [DEPTH];
    logic [30:0]  lease_until [DEPTH];
    logic [15:0]  lease_owner [DEPTH];
    longint       pool_count, dflt_lease, max_lease, min_lease;

    out_item_t    reply_q[$];       // replies still owed by the engine
    int           offered_at[int];  // last address offered to each client
    int           errors = 0;
    longint       cur_now;
    int           send_idle_pct;
    int           stall_pct;
    bit           hold_go;
    bit           hold_on;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #50ms;
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Lease predictor
    // ------------------------------------------------------------------
    function automatic logic [30:0] grant_for(logic [29:0] t, logic [29:0] dl);
        longint d;
        longint r;
        if (dl == 0)
            r = longint'(t) + dflt_lease;
        else
        begin
            d = longint'(dl) - longint'(t);
            if (d >= min_lease && d <= max_lease)
                r = longint'(dl);
            else if (d < min_lease)
                r = longint'(t) + min_lease;
            else
                r = longint'(t) + max_lease;
        end
        return r[30:0];
    endfunction

    function automatic void predict_reply(in_item_t it);
        int        n;
        int        sel;
        bit        found;
        out_item_t r;
        n = (pool_count > DEPTH) ? DEPTH : int'(pool_count);
        // age every in-use entry first
        for (int i = 0; i < n; i++)
        begin
            if (lease_state[i] == ST_OFFERED && lease_until[i] <= it.now)
            begin
                lease_state[i] = ST_FREE;
                lease_owner[i] = '0;
                lease_until[i] = '0;
            end
            else if (lease_state[i] == ST_OCCUPIED && lease_until[i] <= it.now)
            begin
                lease_state[i] = ST_EXPIRED;
                lease_until[i] = '0;
            end
        end
        if (it.op == OP_DISCOVER)
        begin
            if (it.dest_kind != DEST_BCAST)
                return;
            found = 0;
            sel = 0;
            for (int i = 0; i < n && !found; i++)
                if (lease_state[i] != ST_FREE && lease_owner[i] == it.client)
                begin
                    sel = i;
                    found = 1;
                end
            for (int i = 0; i < n && !found; i++)
                if (lease_state[i] == ST_FREE)
                begin
                    sel = i;
                    found = 1;
                end
            for (int i = 0; i < n && !found; i++)
                if (lease_state[i] == ST_EXPIRED)
                begin
                    sel = i;
                    found = 1;
                end
            if (!found)
                return;
            lease_state[sel] = ST_OFFERED;
            lease_owner[sel] = it.client;
            lease_until[sel] = grant_for(it.now, it.deadline);
            r.kind       = KIND_OFFER;
            r.client_res = it.client;
            r.addr_res   = 16'(sel + 1);
            r.expiry     = lease_until[sel];
            reply_q.push_back(r);
            offered_at[int'(it.client)] = sel + 1;
        end
        else if (it.op == OP_REQUEST)
        begin
            if (it.dest_kind == DEST_BCAST)
                return;
            if (it.dest_kind != DEST_SELF)
            begin
                // client chose another server: drop its offers here
                for (int i = 0; i < n; i++)
                    if (lease_state[i] == ST_OFFERED && lease_owner[i] == it.client)
                    begin
                        lease_state[i] = ST_FREE;
                        lease_owner[i] = '0;
                        lease_until[i] = '0;
                    end
                return;
            end
            r.client_res = it.client;
            r.addr_res   = it.addr;
            if (it.addr >= 1 && it.addr <= n && lease_owner[it.addr - 1] == it.client)
            begin
                lease_state[it.addr - 1] = ST_OCCUPIED;
                lease_until[it.addr - 1] = grant_for(it.now, it.deadline);
                r.kind   = KIND_ACK;
                r.expiry = lease_until[it.addr - 1];
            end
            else
            begin
                r.kind   = KIND_NAK;
                r.expiry = '0;
            end
            reply_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Reply side: stall at random, check each accepted reply
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (reply_q.size() == 0)
            begin
                $error("unexpected reply kind %0d client %0d addr %0d",
                       out_data.kind, out_data.client_res, out_data.addr_res);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = reply_q.pop_front();
                if (out_data.kind !== e.kind)
                begin
                    $error("kind: expected %0d, got %0d", e.kind, out_data.kind);
                    errors++;
                end
                if (out_data.client_res !== e.client_res)
                begin
                    $error("client_res: expected %0d, got %0d",
                           e.client_res, out_data.client_res);
                    errors++;
                end
                if (out_data.addr_res !== e.addr_res)
                begin
                    $error("addr_res: expected %0d, got %0d", e.addr_res, out_data.addr_res);
                    errors++;
                end
                if (out_data.expiry !== e.expiry)
                begin
                    $error("expiry: expected %0d, got %0d", e.expiry, out_data.expiry);
                    errors++;
                end
            end
        end
        out_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end

    // Long hold-off of the reply side, counted here
    initial
    begin
        hold_on = 1'b0;
        wait (hold_go);
        hold_on = 1'b1;
        repeat (6 * SETTLE) @(posedge clk);
        hold_on = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------
    // Offer one request; leave valid high so back-to-back requests need no drop.
    task automatic send_request(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_reply(it);
    endtask

    task automatic send_fields(longint t, int c, logic [1:0] d, logic [1:0] o,
                               int a, longint dl);
        in_item_t it;
        it.now       = 30'(t);
        it.client    = 16'(c);
        it.dest_kind = d;
        it.op        = o;
        it.addr      = 16'(a);
        it.deadline  = 30'(dl);
        if (t > cur_now)
            cur_now = t;
        send_request(it);
    endtask

    // Release valid, wait for every owed reply, then let the engine finish its turn.
    task automatic drain();
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(longint pe, longint dfl, longint mx, longint mn, longint sid);
        reg_idx_t idx [5] = '{REG_POOL_ENTRIES, REG_DEFAULT_LEASE, REG_MAX_LEASE,
                              REG_MIN_LEASE, REG_SERVER_ID};
        longint   val [5];
        val = '{pe, dfl, mx, mn, sid};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= CFG_BITS'(val[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        pool_count = pe & 11'h7FF;
        dflt_lease = dfl;
        max_lease  = mx;
        min_lease  = mn;
        offered_at.delete();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        set_config(3, 50, 100, 10, 7);
        send_fields(100, 1, DEST_BCAST, OP_DISCOVER, 0, 0);        // default lease
        send_fields(100, 1, DEST_SELF, OP_DISCOVER, 0, 0);         // unicast DISCOVER ignored
        send_fields(100, 1, DEST_BCAST, OP_REQUEST, 1, 0);         // broadcast REQUEST ignored
        send_fields(100, 1, DEST_BCAST, 2'd2, 1, 0);               // other message types
        send_fields(100, 1, DEST_SELF, 2'd3, 65535, 0);
        send_fields(101, 1, DEST_BCAST, OP_DISCOVER, 0, 102);      // held again, short deadline
        send_fields(101, 1, DEST_SELF, OP_REQUEST, 1, 150);        // ACK, in-range deadline
        send_fields(101, 2, DEST_SELF, OP_REQUEST, 1, 0);          // not the owner: NAK
        send_fields(101, 2, DEST_SELF, OP_REQUEST, 0, 0);          // address zero
        send_fields(101, 2, DEST_SELF, OP_REQUEST, 65535, 0);      // far out of range
        send_fields(102, 2, DEST_BCAST, OP_DISCOVER, 0, 30'h3FFF_FFFF); // clamp to max
        send_fields(102, 3, DEST_BCAST, OP_DISCOVER, 0, 0);
        send_fields(102, 4, DEST_BCAST, OP_DISCOVER, 0, 0);        // pool full, no reply
        send_fields(103, 2, 2'd2, OP_REQUEST, 0, 0);               // release to other server
        send_fields(103, 3, 2'd3, OP_REQUEST, 0, 0);               // unused code acts the same
        send_fields(104, 0, DEST_SELF, OP_REQUEST, 2, 0);          // client zero owns free entry
        send_fields(104, 65535, DEST_BCAST, OP_DISCOVER, 0, 0);
        send_fields(400, 5, DEST_BCAST, OP_DISCOVER, 0, 0);        // leases aged out
        send_fields(400, 1, DEST_SELF, OP_REQUEST, 1, 0);          // owner kept on expired
        send_fields(1000, 6, DEST_BCAST, OP_DISCOVER, 0, 0);
        drain();
        set_config(0, 50, 100, 10, 7);                             // empty pool
        send_fields(1001, 1, DEST_BCAST, OP_DISCOVER, 0, 0);
        send_fields(1001, 1, DEST_SELF, OP_REQUEST, 1, 0);
        drain();
        set_config(2047, 50, 100, 10, 7);                          // oversized pool
        send_fields(1002, 9, DEST_BCAST, OP_DISCOVER, 0, 0);
        send_fields(1002, 9, DEST_SELF, OP_REQUEST, 1024, 0);
        drain();
    endtask

    // Hold the reply side off while requests keep coming, so the engine backs up.
    task automatic test_backpressure();
        set_config(4, 40, 200, 10, 7);
        hold_go = 1'b1;
        for (int i = 0; i < 5; i++)
            send_fields(cur_now + 1, i + 1, DEST_BCAST, OP_DISCOVER, 0, 0);
        drain();
    endtask

    task automatic random_stream(int count, int idle, int stall);
        int        c;
        int        r;
        int        n;
        int        a;
        longint    dl;
        longint    span;
        send_idle_pct = idle;
        stall_pct     = stall;
        n    = (pool_count > DEPTH) ? DEPTH : int'(pool_count);
        span = (max_lease > 400) ? 400 : max_lease + 5;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(19);
            c = (r == 0) ? $urandom_range(65535) : (r == 1) ? 0 : $urandom_range(1, 6);
            cur_now = cur_now + $urandom_range(0, int'(span / 3) + 2);
            if (cur_now > NOW_MAX)
                cur_now = NOW_MAX;
            r = $urandom_range(9);
            if (r < 3)
                dl = 0;
            else if (r < 8)
                dl = cur_now + $urandom_range(0, int'(span) * 2);
            else if (r == 8)
                dl = $urandom_range(30'h3FFF_FFFF);
            else
                dl = cur_now - $urandom_range(0, 50);
            if (dl > NOW_MAX || dl < 0)
                dl = dl & NOW_MAX;
            r = $urandom_range(99);
            if (r < 40)
                send_fields(cur_now, c, DEST_BCAST, OP_DISCOVER, 0, dl);
            else if (r < 75)
            begin
                a = offered_at.exists(c) ? offered_at[c] : $urandom_range(1, n + 1);
                send_fields(cur_now, c, DEST_SELF, OP_REQUEST, a, dl);
            end
            else if (r < 85)
                send_fields(cur_now, c, 2'($urandom_range(2, 3)), OP_REQUEST, 0, dl);
            else
                send_fields(cur_now, c, 2'($urandom_range(3)), 2'($urandom_range(3)),
                            $urandom_range(65535), dl);
        end
        drain();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    task automatic test_small_pool();
        set_config(4, 40, 200, 10, 7);
        random_stream(135, 0, 0);
    endtask

    task automatic test_zero_leases();
        set_config(1, 0, 0, 0, 65535);
        random_stream(135, 70, 0);
    endtask

    task automatic test_wide_window();
        set_config(6, 30, 1000, 0, 300);
        random_stream(135, 30, 30);
    endtask

    // Large times and the widest leases; runs last since time never goes back.
    task automatic test_late_times();
        set_config(2047, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 1);
        cur_now = NOW_MAX - 2000;
        random_stream(135, 0, 70);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cur_now       = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_go       = 1'b0;
        // predictor starts from the reset pool
        for (int i = 0; i < DEPTH; i++)
        begin
            lease_state[i] = ST_FREE;
            lease_until[i] = '0;
            lease_owner[i] = '0;
        end
        pool_count = POOL_ENTRIES_RST;
        dflt_lease = DEFAULT_LEASE_RST;
        max_lease  = MAX_LEASE_RST;
        min_lease  = MIN_LEASE_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_small_pool();
        test_zero_leases();
        test_wide_window();
        test_late_times();

        if (errors == 0 && reply_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
